### src/bnc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker package
// Shared types, character codes and decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_pkg;

  // Character codes of the brackets.
  localparam logic [7:0] CharOpenRound   = 8'h28;
  localparam logic [7:0] CharOpenSquare  = 8'h5B;
  localparam logic [7:0] CharOpenCurly   = 8'h7B;
  localparam logic [7:0] CharOpenAngle   = 8'h3C;
  localparam logic [7:0] CharCloseRound  = 8'h29;
  localparam logic [7:0] CharCloseSquare = 8'h5D;
  localparam logic [7:0] CharCloseCurly  = 8'h7D;
  localparam logic [7:0] CharCloseAngle  = 8'h3E;

  localparam int PointsW = 16;
  localparam int CompW   = 64;
  localparam int SumW    = 48;

  // Bracket kinds, also the stack entry encoding.
  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_ANGLE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_BALANCED   = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_CORRUPT    = 2'd2,
    ST_OVERFLOW   = 2'd3
  } line_status_e;

  typedef enum logic [1:0] {
    REG_POINTS_ROUND  = 2'd0,
    REG_POINTS_SQUARE = 2'd1,
    REG_POINTS_CURLY  = 2'd2,
    REG_POINTS_ANGLE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_RUN,
    S_WALK,
    S_FLUSH
  } state_e;

  localparam logic [PointsW-1:0] PointsRoundRst  = 16'd3;
  localparam logic [PointsW-1:0] PointsSquareRst = 16'd57;
  localparam logic [PointsW-1:0] PointsCurlyRst  = 16'd1197;
  localparam logic [PointsW-1:0] PointsAngleRst  = 16'd25137;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         line_status;
    logic [1:0]         illegal_kind;
    logic [PointsW-1:0] syntax_score;
    logic [CompW-1:0]   completion_score;
    logic [SumW-1:0]    syntax_total;
  } out_item_t;

  // Shift control shared by every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } decode_t;

  function automatic decode_t decode_opener(logic [7:0] c);
    decode_t d;
    d.hit  = 1'b1;
    d.kind = KIND_ROUND;
    case (c)
      CharOpenRound:  d.kind = KIND_ROUND;
      CharOpenSquare: d.kind = KIND_SQUARE;
      CharOpenCurly:  d.kind = KIND_CURLY;
      CharOpenAngle:  d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic decode_t decode_closer(logic [7:0] c);
    decode_t d;
    d.hit  = 1'b1;
    d.kind = KIND_ROUND;
    case (c)
      CharCloseRound:  d.kind = KIND_ROUND;
      CharCloseSquare: d.kind = KIND_SQUARE;
      CharCloseCurly:  d.kind = KIND_CURLY;
      CharCloseAngle:  d.kind = KIND_ANGLE;
      default:         d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### src/bnc_cell.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker stack cell
// One entry of the shifting closer stack; takes its neighbor's kind on push
// or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_cell (
  input  wire logic               clk_i,
  input  wire bnc_pkg::cell_ctrl_t ctrl_i,
  input  wire bnc_pkg::kind_e      above_i,
  input  wire bnc_pkg::kind_e      below_i,
  output bnc_pkg::kind_e           kind_o
);
  import bnc_pkg::*;

  kind_e kind_q, kind_d;

  // A push moves everything one place down, a pop one place up.
  always_comb begin
    kind_d = kind_q;
    if (ctrl_i.push) begin
      kind_d = above_i;
    end else if (ctrl_i.pop) begin
      kind_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

`default_nettype wire

### src/bracket_nesting_checker.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker
// Checks bracket nesting of a character stream line by line and scores it.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in its run state and, for a
// line's last character, while the output register is free. It keeps the
// expected closers in a row of STACK_DEPTH shifting cells whose top sits in
// the first cell, so the top is always at a fixed place. A line that ends
// balanced, corrupt or in depth overflow loads its result transaction into
// the output register at the edge that takes its last character, so the
// result is offered in the next cycle. For a line that ends incomplete with
// closers still open, the stack pops one cell per cycle into the base-5
// completion accumulator (one 67-bit add and saturation check per step), and
// then the flush state places the result in the output register once that
// register is free. No input is taken during that walk or while the result
// waits to be placed. The stack needs no clearing after reset; a depth
// counter marks which cells hold data. The output register lets characters
// that do not end a line keep flowing while a result waits to be taken.
`default_nettype none

module bracket_nesting_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire bnc_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output bnc_pkg::out_item_t               out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire bnc_pkg::cfg_reg_e           cfg_idx_i,
  input  wire logic [bnc_pkg::PointsW-1:0] cfg_data_i
);
  import bnc_pkg::*;

  localparam int DepthW = $clog2(STACK_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthFull = DepthW'(STACK_DEPTH);
  localparam logic [DepthW-1:0] DepthOne  = DepthW'(1);
  localparam logic [DepthW-1:0] DepthZero = '0;
  localparam logic [SumW-1:0]   SumMax    = '1;
  localparam logic [CompW-1:0]  CompMax   = '1;

  // Configuration registers.
  logic [PointsW-1:0] pts_round_q, pts_square_q, pts_curly_q, pts_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_round_q  <= PointsRoundRst;
      pts_square_q <= PointsSquareRst;
      pts_curly_q  <= PointsCurlyRst;
      pts_angle_q  <= PointsAngleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POINTS_ROUND:  pts_round_q  <= cfg_data_i;
        REG_POINTS_SQUARE: pts_square_q <= cfg_data_i;
        REG_POINTS_CURLY:  pts_curly_q  <= cfg_data_i;
        REG_POINTS_ANGLE:  pts_angle_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and per-line state.
  state_e            state_q, state_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              corrupt_q, corrupt_d;
  logic              overflow_q, overflow_d;
  kind_e             illegal_q, illegal_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CompW-1:0]  comp_q, comp_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // Closer stack as a chain of cells; cell 0 holds the top.
  cell_ctrl_t ctrl;
  kind_e      cell_kind [STACK_DEPTH];
  kind_e      new_kind;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_e above, below;
    if (i == 0) begin : g_top
      assign above = new_kind;
    end else begin : g_mid_above
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = KIND_ROUND;
    end else begin : g_mid_below
      assign below = cell_kind[i+1];
    end
    bnc_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .above_i(above),
      .below_i(below),
      .kind_o (cell_kind[i])
    );
  end

  // Character decode.
  decode_t opener, closer;
  logic    active, depth_empty, depth_full, top_match;
  logic    in_hs, out_free;
  logic    set_overflow, set_corrupt, char_push, char_pop;
  logic    cor_nx, ovf_nx;
  kind_e   illegal_nx;
  logic [DepthW-1:0] depth_nx;

  // Completion step: comp * 5 + (kind + 1), saturating.
  logic [2:0]       digit;
  logic [CompW+2:0] comp_wide;
  logic [CompW-1:0] comp_step;

  // Score of the illegal closer and the saturating running total.
  logic [PointsW-1:0] pts_sel;
  logic [SumW:0]      sum_wide;
  logic [SumW-1:0]    sum_add;

  always_comb begin
    opener      = decode_opener(in_data_i.char_code);
    closer      = decode_closer(in_data_i.char_code);
    new_kind    = opener.kind;
    active      = !corrupt_q && !overflow_q;
    depth_empty = (depth_q == DepthZero);
    depth_full  = (depth_q == DepthFull);
    top_match   = (cell_kind[0] == closer.kind);
    out_free    = !out_valid_q || out_ready_i;

    // A character that does not end a line never produces a result, so it
    // may pass while a result still waits in the output register.
    in_ready_o  = (state_q == S_RUN) && (out_free || !in_data_i.line_end);
    in_hs       = in_valid_i && in_ready_o;

    set_overflow = active && opener.hit && depth_full;
    set_corrupt  = active && closer.hit && (depth_empty || !top_match);
    char_push    = active && opener.hit && !depth_full;
    char_pop     = active && closer.hit && !depth_empty && top_match;

    cor_nx     = corrupt_q || set_corrupt;
    ovf_nx     = overflow_q || set_overflow;
    illegal_nx = set_corrupt ? closer.kind : illegal_q;
    depth_nx   = depth_q;
    if (char_push) begin
      depth_nx = depth_q + DepthOne;
    end else if (char_pop) begin
      depth_nx = depth_q - DepthOne;
    end

    digit     = {1'b0, cell_kind[0]} + 3'd1;
    comp_wide = {1'b0, comp_q, 2'b00} + {3'b000, comp_q} + {{CompW{1'b0}}, digit};
    comp_step = (|comp_wide[CompW+2:CompW]) ? CompMax : comp_wide[CompW-1:0];

    case (illegal_nx)
      KIND_ROUND:  pts_sel = pts_round_q;
      KIND_SQUARE: pts_sel = pts_square_q;
      KIND_CURLY:  pts_sel = pts_curly_q;
      KIND_ANGLE:  pts_sel = pts_angle_q;
      default:     pts_sel = pts_round_q;
    endcase
    sum_wide = {1'b0, sum_q} + {{(SumW+1-PointsW){1'b0}}, pts_sel};
    sum_add  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
  end

  // Next state and output register loading.
  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    corrupt_d   = corrupt_q;
    overflow_d  = overflow_q;
    illegal_d   = illegal_q;
    sum_d       = sum_q;
    comp_d      = comp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.push   = 1'b0;
    ctrl.pop    = 1'b0;

    case (state_q)
      S_RUN: begin
        if (in_hs) begin
          ctrl.push  = char_push;
          ctrl.pop   = char_pop;
          depth_d    = depth_nx;
          corrupt_d  = cor_nx;
          overflow_d = ovf_nx;
          illegal_d  = illegal_nx;
          if (in_data_i.line_end) begin
            corrupt_d  = 1'b0;
            overflow_d = 1'b0;
            illegal_d  = KIND_ROUND;
            if (!cor_nx && !ovf_nx && depth_nx != DepthZero) begin
              // Open closers remain: walk the stack for the completion score.
              comp_d  = '0;
              state_d = S_WALK;
            end else begin
              depth_d                     = DepthZero;
              out_valid_d                 = 1'b1;
              out_d.completion_score      = '0;
              out_d.illegal_kind          = KIND_ROUND;
              out_d.syntax_score          = '0;
              out_d.syntax_total          = sum_q;
              if (cor_nx) begin
                out_d.line_status  = ST_CORRUPT;
                out_d.illegal_kind = illegal_nx;
                out_d.syntax_score = pts_sel;
                out_d.syntax_total = sum_add;
                sum_d              = sum_add;
              end else if (ovf_nx) begin
                out_d.line_status = ST_OVERFLOW;
              end else begin
                out_d.line_status = ST_BALANCED;
              end
            end
          end
        end
      end
      S_WALK: begin
        ctrl.pop = 1'b1;
        comp_d   = comp_step;
        depth_d  = depth_q - DepthOne;
        if (depth_q == DepthOne) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.line_status      = ST_INCOMPLETE;
          out_d.illegal_kind     = KIND_ROUND;
          out_d.syntax_score     = '0;
          out_d.completion_score = comp_q;
          out_d.syntax_total     = sum_q;
          state_d                = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      depth_q     <= DepthZero;
      corrupt_q   <= 1'b0;
      overflow_q  <= 1'b0;
      illegal_q   <= KIND_ROUND;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      corrupt_q   <= corrupt_d;
      overflow_q  <= overflow_d;
      illegal_q   <= illegal_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    comp_q <= comp_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
